/* rtl/kls_pkg.sv */
`timescale 1ns / 1ps
// kls_pkg: shared constants, types and operation codes for the k-th largest selector.
// Used by kls_cell and kth_largest_selector; depends on nothing else.
package kls_pkg;

  localparam int HEAP_CAPACITY = 1024;
  localparam int DATA_W        = 32;
  localparam int RANK_W        = 11;
  localparam int FILL_W        = $clog2(HEAP_CAPACITY + 1);
  localparam int CMP_W         = (FILL_W > RANK_W) ? FILL_W : RANK_W;

  // Operation broadcast to every cell in one cycle.
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REPLACE
  } op_t;

  // What a cell shows its neighbors: its entry and how it compares with the new value.
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     le;  // holds an entry and entry <= new value
    logic                     lt;  // holds an entry and entry <  new value
  } cell_out_t;

endpackage

/* rtl/kls_cell.sv */
`timescale 1ns / 1ps
// kls_cell: one slot of the sorted chain; holds one entry and shifts with its neighbors.
// Depends on kls_pkg.
module kls_cell (
  input  logic                                  clk,
  input  logic                                  valid,
  input  kls_pkg::op_t                          op,
  input  logic signed [kls_pkg::DATA_W-1:0]     new_value,
  input  kls_pkg::cell_out_t                    left,
  input  kls_pkg::cell_out_t                    right,
  output kls_pkg::cell_out_t                    status
);

  logic signed [kls_pkg::DATA_W-1:0] entry;
  logic signed [kls_pkg::DATA_W-1:0] entry_next;
  logic                              le;
  logic                              lt;

  assign le = valid && (entry <= new_value);
  assign lt = valid && (entry < new_value);

  assign status.value = entry;
  assign status.le    = le;
  assign status.lt    = lt;

  // Insert opens a gap at the first entry above the new value; replace drops
  // the smallest entry and closes the chain around the new value.
  always_comb begin
    entry_next = entry;
    case (op)
      kls_pkg::OP_INSERT: begin
        if (!le) begin
          if (left.le) begin
            entry_next = new_value;
          end else begin
            entry_next = $signed(left.value);
          end
        end
      end
      kls_pkg::OP_REPLACE: begin
        if (right.lt) begin
          entry_next = $signed(right.value);
        end else if (lt) begin
          entry_next = new_value;
        end
      end
      default: begin
        entry_next = entry;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

/* rtl/kth_largest_selector.sv */
`timescale 1ns / 1ps
// kth_largest_selector: reports the k-th largest value of each set of signed values.
// Throughput: one item per cycle unless stalled; each is a compare-and-shift step in every cell.
// The last item's transfer sets fin, and input stalls until the result is registered.
// Reset (synchronous): clears the fill count, handshake state and sets rank to 1.
// Cell contents are not cleared; a cell is only read while it lies below the fill count.
// Depends on kls_pkg and kls_cell.
module kth_largest_selector (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration write channel.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [kls_pkg::RANK_W-1:0]        k_rank,
  // Input items.
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [kls_pkg::DATA_W-1:0] value,
  input  logic                              last,
  // Results.
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [kls_pkg::DATA_W-1:0] kth_largest,
  output logic                              fewer_than_k
);

  localparam int CAP = kls_pkg::HEAP_CAPACITY;

  // The entries are kept as a chain of cells sorted ascending from cell 0.
  // Only the multiset of entries matters to the result, and its minimum sits
  // in cell 0, so the chain gives the same answers as a bounded min-heap.
  // Cells at or above the fill count act as empty slots with no entry.

  logic [kls_pkg::RANK_W-1:0]  rank;
  logic [kls_pkg::FILL_W-1:0]  fill_count;
  logic [kls_pkg::FILL_W-1:0]  fill_next;
  logic [kls_pkg::FILL_W-1:0]  eff_k;
  logic [kls_pkg::CMP_W-1:0]   rank_wide;
  logic                        fin;
  logic                        fewer;
  logic                        in_xfer;
  logic                        out_free;
  logic                        load_out;
  kls_pkg::op_t                op;
  kls_pkg::cell_out_t          cell_st [CAP];
  kls_pkg::cell_out_t          edge_left;
  kls_pkg::cell_out_t          edge_right;

  // Always writable; software must write the register only while the block is idle, unenforced.
  assign cfg_ready = 1'b1;

  // A rank of zero acts as one, and a rank above capacity acts as capacity.
  assign rank_wide = kls_pkg::CMP_W'(rank);
  always_comb begin
    if (rank == '0) begin
      eff_k = kls_pkg::FILL_W'(1);
    end else if (rank_wide > kls_pkg::CMP_W'(CAP)) begin
      eff_k = kls_pkg::FILL_W'(CAP);
    end else begin
      eff_k = kls_pkg::FILL_W'(rank_wide);
    end
  end

  // Input is held off only while a finished set waits to move into the output register.
  assign in_stall = fin;
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign load_out = fin && out_free;

  // While the set is short of k entries each value goes in; afterwards a value
  // strictly above the smallest entry replaces it, and anything else is dropped.
  always_comb begin
    op        = kls_pkg::OP_HOLD;
    fill_next = fill_count;
    if (in_xfer) begin
      if (fill_count < eff_k) begin
        op        = kls_pkg::OP_INSERT;
        fill_next = fill_count + kls_pkg::FILL_W'(1);
      end else if (cell_st[0].lt) begin
        op = kls_pkg::OP_REPLACE;
      end
    end
  end

  // The slot left of cell 0 behaves as a value below everything, and the slot
  // right of the final cell holds no entry.
  assign edge_left.value  = '0;
  assign edge_left.le     = 1'b1;
  assign edge_left.lt     = 1'b1;
  assign edge_right.value = '0;
  assign edge_right.le    = 1'b0;
  assign edge_right.lt    = 1'b0;

  for (genvar i = 0; i < CAP; i++) begin : g_cell
    kls_pkg::cell_out_t left_st;
    kls_pkg::cell_out_t right_st;
    logic               slot_valid;

    if (i == 0) begin : g_first
      assign left_st = edge_left;
    end else begin : g_inner_left
      assign left_st = cell_st[i-1];
    end

    if (i == CAP - 1) begin : g_final
      assign right_st = edge_right;
    end else begin : g_inner_right
      assign right_st = cell_st[i+1];
    end

    assign slot_valid = fill_count > kls_pkg::FILL_W'(i);

    kls_cell u_cell (
      .clk       (clk),
      .valid     (slot_valid),
      .op        (op),
      .new_value (value),
      .left      (left_st),
      .right     (right_st),
      .status    (cell_st[i])
    );
  end

  // Control and output registers. The short flag is settled when the last item
  // is taken, with the rank in force then; the root is read on the load, once
  // the chain has absorbed that item and the output register is free. Emptying
  // the set is just clearing the fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      rank       <= kls_pkg::RANK_W'(1);
      fill_count <= '0;
      fin        <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        rank <= k_rank;
      end
      if (load_out) begin
        fill_count <= '0;
        fin        <= 1'b0;
        out_valid  <= 1'b1;
      end else begin
        fill_count <= fill_next;
        if (in_xfer && last) begin
          fin <= 1'b1;
        end
        if (out_valid && !out_stall) begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && last) begin
      fewer <= fill_next < eff_k;
    end
    if (load_out) begin
      kth_largest  <= $signed(cell_st[0].value);
      fewer_than_k <= fewer;
    end
  end

  // The fill count never runs past the number of cells.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= kls_pkg::FILL_W'(CAP))
    else $error("fill count exceeds capacity");

  // The two lowest entries stay in order, so cell 0 always holds the minimum.
  a_root_min: assert property (@(posedge clk) disable iff (rst)
    (fill_count >= kls_pkg::FILL_W'(2)) |->
      ($signed(cell_st[0].value) <= $signed(cell_st[1].value)))
    else $error("chain out of order at the root");

  // An insert grows the set by exactly one entry.
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (op == kls_pkg::OP_INSERT) |=>
      (fill_count == $past(fill_count) + kls_pkg::FILL_W'(1)))
    else $error("insert did not grow the fill count");

  // A last item always leads to the finishing step.
  a_last_fin: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && last) |=> fin)
    else $error("last item did not start the finishing step");

  // Moving a result into the output register empties the set.
  a_load_clears: assert property (@(posedge clk) disable iff (rst)
    load_out |=> (out_valid && !fin && fill_count == '0))
    else $error("result load did not empty the set");

endmodule
